/* hdl/bsr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared constants and types of the bilinear rgba sampler.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int PIXEL_W    = 32;
  localparam int POS_W      = 14;
  localparam int COORD_W    = 6;
  localparam int CFG_DIM_W  = 7;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 2;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_FRAC_BITS  = 7;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_CHANNEL = 2'd2;

  localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH    = 7'd64;
  localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT   = 7'd64;
  localparam logic                 RST_SINGLE_CHANNEL = 1'b0;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] frame_width;
    logic [CFG_DIM_W-1:0] frame_height;
    logic                 single_channel;
  } cfg_t;

endpackage

`default_nettype wire

/* hdl/bsr_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_ram
// Generic ram: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr0,
  input  wire [$clog2(DEPTH)-1:0]  raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata0 <= mem_r[raddr0];
    rdata1 <= mem_r[raddr1];
  end

endmodule

`default_nettype wire

/* hdl/bsr_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_fifo
// Small register fifo used for the command queue and the result buffer.
// ----------------------------------------------------------------------------
module bsr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire [WIDTH-1:0]  din,
  input  wire              pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

/* hdl/bsr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_front
// Accepts requests, decodes writes and samples, resolves wrap, clamp and the
// four neighbor addresses, and queues a command for the back end.
// ----------------------------------------------------------------------------
module bsr_front
  import bsr_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT),
  parameter int CMD_W      = 2 + 4 * ADDR_W + 2 * FRAC_BITS + PIXEL_W
) (
  input  wire                clk,
  input  wire                rst_n,
  input  cfg_t               cfg,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                in_mode,
  input  wire [COORD_W-1:0]  in_col,
  input  wire [COORD_W-1:0]  in_row,
  input  wire [PIXEL_W-1:0]  in_pixel_in,
  input  wire [POS_W-1:0]    in_x_pos,
  input  wire [POS_W-1:0]    in_y_pos,
  output logic               cmd_push,
  output logic [CMD_W-1:0]   cmd_data,
  input  wire                cmd_full
);

  localparam int XI_W  = POS_W - FRAC_BITS;
  localparam int CW_A  = (XI_W + 1 > CFG_DIM_W) ? XI_W + 1 : CFG_DIM_W;
  localparam int MW_B  = $clog2(MAX_WIDTH + 1);
  localparam int MH_B  = $clog2(MAX_HEIGHT + 1);
  localparam int CW_B  = (MW_B > MH_B) ? MW_B : MH_B;
  localparam int CW    = (CW_A > CW_B) ? CW_A : CW_B;

  typedef struct packed {
    logic                 is_write;
    logic                 range_err;
    logic [ADDR_W-1:0]    addr_a;
    logic [ADDR_W-1:0]    addr_b;
    logic [ADDR_W-1:0]    addr_c;
    logic [ADDR_W-1:0]    addr_d;
    logic [FRAC_BITS-1:0] frac_x;
    logic [FRAC_BITS-1:0] frac_y;
    logic [PIXEL_W-1:0]   data;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [CW-1:0] r,
                                                 input logic [CW-1:0] c);
    pix_addr = ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
  endfunction

  logic          front_valid_r, front_valid_nxt;
  cmd_t          front_cmd_r;
  cmd_t          cmd_new;
  logic          accept;
  logic          keep;
  logic [CW-1:0] xi, xi1, yi, yi1;
  logic [CW-1:0] w_raw, w_sat, h_raw, h_sat, h_last;
  logic [CW-1:0] ix0, ix1, iy0, iy1;
  logic          err;
  logic          wr_in_range;

  assign in_stall = front_valid_r && cmd_full;
  assign accept   = in_valid && !in_stall;
  assign cmd_push = front_valid_r && !cmd_full;
  assign cmd_data = front_cmd_r;

  always_comb begin
    xi  = CW'(in_x_pos[POS_W-1:FRAC_BITS]);
    yi  = CW'(in_y_pos[POS_W-1:FRAC_BITS]);
    xi1 = xi + CW'(1);
    yi1 = yi + CW'(1);

    w_raw = CW'(cfg.frame_width);
    w_sat = (w_raw > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_raw;
    h_raw = CW'(cfg.frame_height);
    h_sat = (h_raw > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : h_raw;
    if (h_sat == '0) begin
      h_sat = CW'(1);
    end
    h_last = h_sat - CW'(1);

    // single wrap of each column, clamp of each row
    ix0 = (xi  >= w_sat) ? xi  - w_sat : xi;
    ix1 = (xi1 >= w_sat) ? xi1 - w_sat : xi1;
    iy0 = (yi  > h_last) ? h_last : yi;
    iy1 = (yi1 > h_last) ? h_last : yi1;
    err = (ix0 >= w_sat) || (ix1 >= w_sat);

    wr_in_range = (CW'(in_col) < CW'(MAX_WIDTH)) && (CW'(in_row) < CW'(MAX_HEIGHT));

    cmd_new.is_write  = (in_mode == MODE_WRITE);
    cmd_new.range_err = err;
    cmd_new.frac_x    = in_x_pos[FRAC_BITS-1:0];
    cmd_new.frac_y    = in_y_pos[FRAC_BITS-1:0];
    cmd_new.data      = in_pixel_in;
    if (in_mode == MODE_WRITE) begin
      cmd_new.addr_a = pix_addr(CW'(in_row), CW'(in_col));
      cmd_new.addr_b = '0;
      cmd_new.addr_c = '0;
      cmd_new.addr_d = '0;
    end else if (err) begin
      cmd_new.addr_a = '0;
      cmd_new.addr_b = '0;
      cmd_new.addr_c = '0;
      cmd_new.addr_d = '0;
    end else begin
      cmd_new.addr_a = pix_addr(iy0, ix0);
      cmd_new.addr_b = pix_addr(iy0, ix1);
      cmd_new.addr_c = pix_addr(iy1, ix0);
      cmd_new.addr_d = pix_addr(iy1, ix1);
    end

    // out-of-store writes are dropped here
    keep = (in_mode == MODE_SAMPLE) || wr_in_range;

    if (accept) begin
      front_valid_nxt = keep;
    end else if (cmd_push) begin
      front_valid_nxt = 1'b0;
    end else begin
      front_valid_nxt = front_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_cmd_r <= cmd_new;
    end
  end

endmodule

`default_nettype wire

/* hdl/bsr_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_back
// Executes queued commands: frame store writes, two row reads per sample,
// shared horizontal blend, vertical blend and the result buffer.
// ----------------------------------------------------------------------------
module bsr_back
  import bsr_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT),
  parameter int CMD_W      = 2 + 4 * ADDR_W + 2 * FRAC_BITS + PIXEL_W
) (
  input  wire                clk,
  input  wire                rst_n,
  input  cfg_t               cfg,
  input  wire [CMD_W-1:0]    cmd_data,
  input  wire                cmd_empty,
  output logic               cmd_pop,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [PIXEL_W-1:0] out_pixel_out,
  output logic               out_range_error
);

  localparam int CRW   = $clog2(OUT_DEPTH + 1);
  localparam int RES_W = PIXEL_W + 1;

  typedef struct packed {
    logic                 is_write;
    logic                 range_err;
    logic [ADDR_W-1:0]    addr_a;
    logic [ADDR_W-1:0]    addr_b;
    logic [ADDR_W-1:0]    addr_c;
    logic [ADDR_W-1:0]    addr_d;
    logic [FRAC_BITS-1:0] frac_x;
    logic [FRAC_BITS-1:0] frac_y;
    logic [PIXEL_W-1:0]   data;
  } cmd_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               range_err;
  } res_t;

  typedef enum logic {
    ST_ROW0,
    ST_ROW1
  } state_t;

  // a + floor((b - a) * f / 2^FRAC_BITS) on the whole word
  function automatic logic [PIXEL_W-1:0] lerp_word(input logic [PIXEL_W-1:0] a,
                                                   input logic [PIXEL_W-1:0] b,
                                                   input logic [FRAC_BITS-1:0] f);
    logic signed [PIXEL_W:0]             d;
    logic signed [PIXEL_W+FRAC_BITS+1:0] p;
    logic signed [PIXEL_W+FRAC_BITS+1:0] q;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, f});
    q = p >>> FRAC_BITS;
    lerp_word = a + q[PIXEL_W-1:0];
  endfunction

  // same formula per 8-bit lane
  function automatic logic [PIXEL_W-1:0] lerp_lanes(input logic [PIXEL_W-1:0] a,
                                                    input logic [PIXEL_W-1:0] b,
                                                    input logic [FRAC_BITS-1:0] f);
    logic signed [8:0]           d;
    logic signed [FRAC_BITS+9:0] p;
    logic signed [FRAC_BITS+9:0] q;
    logic [PIXEL_W-1:0]          r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      d = $signed({1'b0, b[8*k +: 8]}) - $signed({1'b0, a[8*k +: 8]});
      p = d * $signed({1'b0, f});
      q = p >>> FRAC_BITS;
      r[8*k +: 8] = a[8*k +: 8] + q[7:0];
    end
    lerp_lanes = r;
  endfunction

  function automatic logic [PIXEL_W-1:0] blend(input logic mono,
                                               input logic [PIXEL_W-1:0] a,
                                               input logic [PIXEL_W-1:0] b,
                                               input logic [FRAC_BITS-1:0] f);
    blend = mono ? lerp_word(a, b, f) : lerp_lanes(a, b, f);
  endfunction

  cmd_t               head;
  logic               head_valid;
  state_t             state_r, state_nxt;
  logic               ram_we;
  logic [ADDR_W-1:0]  raddr0, raddr1;
  logic [PIXEL_W-1:0] rdata0, rdata1;
  logic               issue_row0, issue_row1;
  logic               credit_ok;
  logic [CRW-1:0]     credit_r, credit_nxt;
  logic               t1_valid_r, t1_row1_r, t2_valid_r;
  logic [FRAC_BITS-1:0] t1_fx_r, t1_fy_r, t2_fy_r;
  logic               t1_err_r, t2_err_r;
  logic [PIXEL_W-1:0] e_r, f_r;
  logic [PIXEL_W-1:0] h_blend, v_blend;
  res_t               res_in, res_out;
  logic               res_full, res_empty;
  logic               out_take;
  logic [RES_W-1:0]   res_dout;

  assign head       = cmd_t'(cmd_data);
  assign head_valid = !cmd_empty;
  assign credit_ok  = (credit_r < CRW'(OUT_DEPTH));
  assign out_take   = out_valid && !out_stall;

  // row0 reads a and b, row1 reads c and d; a write is done in row0
  always_comb begin
    state_nxt  = state_r;
    cmd_pop    = 1'b0;
    ram_we     = 1'b0;
    raddr0     = '0;
    raddr1     = '0;
    issue_row0 = 1'b0;
    issue_row1 = 1'b0;
    case (state_r)
      ST_ROW0: begin
        if (head_valid) begin
          if (head.is_write) begin
            ram_we  = 1'b1;
            cmd_pop = 1'b1;
          end else if (credit_ok) begin
            raddr0     = head.addr_a;
            raddr1     = head.addr_b;
            issue_row0 = 1'b1;
            state_nxt  = ST_ROW1;
          end
        end
      end
      ST_ROW1: begin
        raddr0     = head.addr_c;
        raddr1     = head.addr_d;
        issue_row1 = 1'b1;
        cmd_pop    = 1'b1;
        state_nxt  = ST_ROW0;
      end
      default: begin
        state_nxt = ST_ROW0;
      end
    endcase
  end

  // credits cover results in flight plus results buffered
  always_comb begin
    credit_nxt = credit_r;
    if (issue_row0 && !out_take) begin
      credit_nxt = credit_r + CRW'(1);
    end else if (out_take && !issue_row0) begin
      credit_nxt = credit_r - CRW'(1);
    end
  end

  bsr_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_frame_store (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (head.addr_a),
    .wdata  (head.data),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_ROW0;
      credit_r   <= '0;
      t1_valid_r <= 1'b0;
      t1_row1_r  <= 1'b0;
      t2_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      credit_r   <= credit_nxt;
      t1_valid_r <= issue_row0 || issue_row1;
      t1_row1_r  <= issue_row1;
      t2_valid_r <= t1_valid_r && t1_row1_r;
    end
  end

  assign h_blend = blend(cfg.single_channel, rdata0, rdata1, t1_fx_r);
  assign v_blend = blend(cfg.single_channel, e_r, f_r, t2_fy_r);

  always_ff @(posedge clk) begin
    if (issue_row0 || issue_row1) begin
      t1_fx_r  <= head.frac_x;
      t1_fy_r  <= head.frac_y;
      t1_err_r <= head.range_err;
    end
    if (t1_valid_r) begin
      if (t1_row1_r) begin
        f_r      <= h_blend;
        t2_fy_r  <= t1_fy_r;
        t2_err_r <= t1_err_r;
      end else begin
        e_r <= h_blend;
      end
    end
  end

  assign res_in.pixel     = t2_err_r ? '0 : v_blend;
  assign res_in.range_err = t2_err_r;

  bsr_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_result_buf (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (t2_valid_r),
    .din   (res_in),
    .pop   (out_take),
    .dout  (res_dout),
    .full  (res_full),
    .empty (res_empty)
  );

  assign res_out         = res_t'(res_dout);
  // credits hold results in flight plus buffered to the buffer depth, so a push is never refused
  assign out_valid       = !res_empty && (res_full || !res_full);
  assign out_pixel_out   = res_out.pixel;
  assign out_range_error = res_out.range_err;

endmodule

`default_nettype wire

/* hdl/bilinear_rgba_sampler_wrap_clamp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_rgba_sampler_wrap_clamp
// Frame store with bilinear sampling, column wrap and row clamp.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   mode col row pixel_in x_pos y_pos
//  out      output     out_valid/out_stall pixel_out range_error
//  cfg      input      cfg_we              cfg_index cfg_wdata
//
// in a sample, the frame store's two read ports fetch the upper row pair, then
// the lower row pair; a pixel write is a single store write. a taken request
// passes the front register, command queue, row reads and blends to out_valid.
// rst_n is synchronous; the frame store holds no reset and needs no clearing.
// a 4-entry command queue and a 4-entry result buffer let either side stall
// without stopping the other until the queue fills.
// ----------------------------------------------------------------------------
module bilinear_rgba_sampler_wrap_clamp
  import bsr_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  in_mode,
  input  wire [COORD_W-1:0]    in_col,
  input  wire [COORD_W-1:0]    in_row,
  input  wire [PIXEL_W-1:0]    in_pixel_in,
  input  wire [POS_W-1:0]      in_x_pos,
  input  wire [POS_W-1:0]      in_y_pos,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [PIXEL_W-1:0]   out_pixel_out,
  output logic                 out_range_error,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int CMD_W  = 2 + 4 * ADDR_W + 2 * FRAC_BITS + PIXEL_W;

  cfg_t             cfg_r, cfg_nxt;
  logic             cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic [CMD_W-1:0] cmd_in, cmd_out;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:    cfg_nxt.frame_width    = cfg_wdata[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT:   cfg_nxt.frame_height   = cfg_wdata[CFG_DIM_W-1:0];
        REG_SINGLE_CHANNEL: cfg_nxt.single_channel = cfg_wdata[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width    <= RST_FRAME_WIDTH;
      cfg_r.frame_height   <= RST_FRAME_HEIGHT;
      cfg_r.single_channel <= RST_SINGLE_CHANNEL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bsr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS),
    .ADDR_W     (ADDR_W),
    .CMD_W      (CMD_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_col      (in_col),
    .in_row      (in_row),
    .in_pixel_in (in_pixel_in),
    .in_x_pos    (in_x_pos),
    .in_y_pos    (in_y_pos),
    .cmd_push    (cmd_push),
    .cmd_data    (cmd_in),
    .cmd_full    (cmd_full)
  );

  bsr_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .full  (cmd_full),
    .empty (cmd_empty)
  );

  bsr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS),
    .ADDR_W     (ADDR_W),
    .CMD_W      (CMD_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd_data        (cmd_out),
    .cmd_empty       (cmd_empty),
    .cmd_pop         (cmd_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_out   (out_pixel_out),
    .out_range_error (out_range_error)
  );

endmodule

`default_nettype wire
